// ===== design/bdhc_pkg.sv =====
// Package: shared types and constants for the button debounce hold/click block.
`default_nettype none

package bdhc_pkg;

  // Button state codes
  localparam logic [1:0] ST_RELEASED = 2'd0;
  localparam logic [1:0] ST_PRESSED  = 2'd1;
  localparam logic [1:0] ST_HELD     = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 2'd1;

  // Configuration reset values
  localparam logic [15:0] DEBOUNCE_RST = 16'd50;
  localparam logic [15:0] HOLD_RST     = 16'd1000;

  // One pin sample
  typedef struct packed {
    logic        pin_level;
    logic [31:0] now_ms;
    logic        consume_click;
  } in_t;

  // One result
  typedef struct packed {
    logic [1:0] button_state;
    logic       clicked;
  } out_t;

  // Timing configuration
  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] hold_ms;
  } cfg_t;

endpackage

`default_nettype wire

// ===== design/bdhc_fsm.sv =====
// Debounce and press state machine: state registers and next-state logic.
`default_nettype none

module bdhc_fsm (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire bdhc_pkg::in_t    sample_i,
  input  wire bdhc_pkg::cfg_t   cfg_i,
  output bdhc_pkg::out_t        result_o
);

  logic [1:0]  state_q, state_d;
  logic        deb_q, deb_d;
  logic [31:0] start_q, start_d;
  logic        click_q, click_d;

  logic        active;
  logic [31:0] elapsed;
  logic        deb_ok;
  logic        hold_ok;
  logic        click_rep;

  // Elapsed time since debounce start, wrapping
  assign active  = ~sample_i.pin_level;
  assign elapsed = sample_i.now_ms - start_q;
  assign deb_ok  = elapsed >= {16'd0, cfg_i.debounce_ms};
  assign hold_ok = elapsed >= {16'd0, cfg_i.hold_ms};

  // Compute the next state for this sample
  always_comb begin
    state_d   = state_q;
    deb_d     = deb_q;
    start_d   = start_q;
    click_rep = click_q;

    // Open the window or accept the press
    if (active && (state_q == bdhc_pkg::ST_RELEASED)) begin
      if (!deb_q) begin
        deb_d     = 1'b1;
        start_d   = sample_i.now_ms;
        click_rep = 1'b0;
      end else if (deb_ok) begin
        state_d = bdhc_pkg::ST_PRESSED;
      end
    end

    // Release: close the window, flag a click from pressed
    if (!active) begin
      case (state_q)
        bdhc_pkg::ST_PRESSED: begin
          deb_d     = 1'b0;
          click_rep = 1'b1;
          state_d   = bdhc_pkg::ST_RELEASED;
        end
        bdhc_pkg::ST_HELD: begin
          deb_d   = 1'b0;
          state_d = bdhc_pkg::ST_RELEASED;
        end
        default: begin
        end
      endcase
    end

    // Promote to held; start is unchanged outside released
    if ((state_d == bdhc_pkg::ST_PRESSED) && hold_ok) begin
      state_d = bdhc_pkg::ST_HELD;
    end

    click_d = click_rep & ~sample_i.consume_click;
  end

  assign result_o.button_state = state_d;
  assign result_o.clicked      = click_rep;

  // Advance state once per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bdhc_pkg::ST_RELEASED;
      deb_q   <= 1'b0;
      start_q <= 32'd0;
      click_q <= 1'b0;
    end else if (step_i) begin
      state_q <= state_d;
      deb_q   <= deb_d;
      start_q <= start_d;
      click_q <= click_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/button_debounce_hold_click.sv =====
// Top level: button debounce with click and long-press detection.
`default_nettype none

// Takes one active-low pin sample with a millisecond timestamp per transaction
// and returns one result (released, pressed or held, plus a pending-click flag)
// per sample. A sample can be accepted every clock cycle while the result is not
// stalled. The accepted sample is held in the input register, and the state
// update loads its result into the result register. The state update is a
// 32-bit wrapping subtract and two compares against the debounce and hold
// limits. When the result is stalled, one more sample is held in the input
// register before ready drops. Configuration (index 0 debounce_ms, index 1
// hold_ms) is to be written through the plain write port only while no sample
// is in flight; the block does not enforce this. Other indexes are ignored.
module button_debounce_hold_click (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire bdhc_pkg::in_t                      in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output bdhc_pkg::out_t                          out_data_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [bdhc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [15:0]                        cfg_wdata_i
);

  bdhc_pkg::cfg_t cfg_q;
  bdhc_pkg::in_t  s1_data_q;
  logic           s1_valid_q;
  logic           s1_adv;
  bdhc_pkg::out_t res;
  bdhc_pkg::out_t out_q;
  logic           out_valid_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms <= bdhc_pkg::DEBOUNCE_RST;
      cfg_q.hold_ms     <= bdhc_pkg::HOLD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bdhc_pkg::CFG_DEBOUNCE: cfg_q.debounce_ms <= cfg_wdata_i;
        bdhc_pkg::CFG_HOLD:     cfg_q.hold_ms     <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Stage handshake
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  // Input register: hold the accepted sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_data_q <= in_data_i;
    end
  end

  // State update for the sample in the input register
  bdhc_fsm u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_adv),
    .sample_i (s1_data_q),
    .cfg_i    (cfg_q),
    .result_o (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  // An accepted sample lands in the input register
  a_in_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> s1_valid_q)
    else $error("accepted sample not captured");

  // A sample leaving the input register always produces a result
  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_o)
    else $error("result not loaded after state update");

  // No click can be pending while the button is down
  a_no_click_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.button_state != bdhc_pkg::ST_RELEASED))
      |-> !out_data_o.clicked)
    else $error("click pending while pressed or held");

  // Only released, pressed and held are reported
  a_state_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.button_state == bdhc_pkg::ST_RELEASED ||
                     out_data_o.button_state == bdhc_pkg::ST_PRESSED ||
                     out_data_o.button_state == bdhc_pkg::ST_HELD))
    else $error("invalid button state reported");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_button_debounce_hold_click.sv =====
// Testbench for the button debounce block: directed corners, then random press sequences.
`timescale 1ns / 100ps

module tb_button_debounce_hold_click;
  import bdhc_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 10;
  localparam int MAX_REPORTED = 10;
  // Indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready_o;
  in_t in_data = '0;
  logic out_valid_o;
  logic out_ready = 1'b0;
  out_t out_data_o;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [15:0] cfg_wdata = '0;

  // Predicted block state and timing registers
  logic [15:0] debounce_lim;
  logic [15:0] hold_lim;
  logic [1:0] btn_state;
  logic debounce_open;
  logic [31:0] window_start_ms;
  logic click_flag;

  out_t predicted_reports[$];
  int fail_count = 0;
  int samples_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;
  logic [31:0] wall_ms = '0;

  button_debounce_hold_click i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTED) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
  endfunction

  // Advance the predicted state by one pin sample and return its report
  function automatic out_t predict_report(in_t s);
    logic active;
    logic [31:0] elapsed;
    out_t r;
    active = !s.pin_level;
    if (active && btn_state == ST_RELEASED) begin
      if (!debounce_open) begin
        debounce_open = 1'b1;
        window_start_ms = s.now_ms;
        click_flag = 1'b0;
      end else begin
        elapsed = s.now_ms - window_start_ms;
        if (elapsed >= {16'd0, debounce_lim}) btn_state = ST_PRESSED;
      end
    end
    // Release from pressed or held closes the window; only pressed clicks
    if (!active && btn_state != ST_RELEASED) begin
      debounce_open = 1'b0;
      if (btn_state == ST_PRESSED) click_flag = 1'b1;
      btn_state = ST_RELEASED;
    end
    elapsed = s.now_ms - window_start_ms;
    if (btn_state == ST_PRESSED && elapsed >= {16'd0, hold_lim}) btn_state = ST_HELD;
    r.button_state = btn_state;
    r.clicked = click_flag;
    if (s.consume_click) click_flag = 1'b0;
    return r;
  endfunction

  // Drive one sample, hold it until accepted, then log its prediction
  task automatic send_sample(input logic pin, input logic [31:0] now, input logic consume);
    in_t s;
    s.pin_level = pin;
    s.now_ms = now;
    s.consume_click = consume;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk_i); while (!in_ready_o);
    predicted_reports.push_back(predict_report(s));
    samples_sent++;
  endtask

  // Drop valid and wait until every pending report has come back
  task automatic drain_samples();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (predicted_reports.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_timing(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DEBOUNCE: debounce_lim = value;
      CFG_HOLD: hold_lim = value;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Reset timing: debounce, bounce, hold, click and click consume
  task automatic test_press_release_click();
    send_sample(1'b1, 32'd0, 1'b0);
    send_sample(1'b0, 32'd100, 1'b0);
    send_sample(1'b1, 32'd120, 1'b0);
    send_sample(1'b0, 32'd150, 1'b0);
    send_sample(1'b0, 32'd1099, 1'b0);
    send_sample(1'b0, 32'd1100, 1'b0);
    send_sample(1'b1, 32'd1200, 1'b0);
    send_sample(1'b0, 32'd2000, 1'b0);
    send_sample(1'b0, 32'd2060, 1'b0);
    send_sample(1'b1, 32'd2100, 1'b0);
    send_sample(1'b1, 32'd2101, 1'b1);
    send_sample(1'b1, 32'd2102, 1'b1);
    drain_samples();
  endtask

  // Timestamp wrap, hold below debounce, zero debounce, time going backwards
  task automatic test_timing_corners();
    write_timing(CFG_DEBOUNCE, 16'd100);
    write_timing(CFG_HOLD, 16'd10);
    send_sample(1'b0, 32'hFFFF_FFC0, 1'b0);
    send_sample(1'b0, 32'h0000_0030, 1'b0);
    send_sample(1'b1, 32'h0000_0040, 1'b0);
    drain_samples();
    write_timing(CFG_DEBOUNCE, 16'd0);
    write_timing(CFG_HOLD, 16'hFFFF);
    send_sample(1'b0, 32'd5, 1'b0);
    send_sample(1'b0, 32'd5, 1'b0);
    send_sample(1'b1, 32'd6, 1'b1);
    drain_samples();
    write_timing(CFG_DEBOUNCE, 16'hFFFF);
    send_sample(1'b0, 32'd1000, 1'b0);
    send_sample(1'b0, 32'd999, 1'b0);
    send_sample(1'b1, 32'hFFFF_FFFF, 1'b1);
    drain_samples();
    // Writes to unused indexes must leave both limits alone
    write_timing(CFG_SPARE_LO, 16'd0);
    write_timing(CFG_SPARE_HI, 16'd0);
    send_sample(1'b0, 32'd0, 1'b0);
    send_sample(1'b0, 32'd1, 1'b0);
    send_sample(1'b1, 32'd2, 1'b0);
    drain_samples();
  endtask

  // One press: mostly active samples with bounces, then a short release
  task automatic send_press_episode();
    int step_max;
    int n_down;
    int n_up;
    step_max = $urandom_range(1, 4) * 10;
    n_down = $urandom_range(1, 12);
    n_up = $urandom_range(1, 4);
    if ($urandom_range(7) == 0) wall_ms = $urandom;
    for (int i = 0; i < n_down; i++) begin
      wall_ms += $urandom_range(0, step_max);
      send_sample($urandom_range(9) == 0, wall_ms, $urandom_range(3) == 0);
    end
    for (int i = 0; i < n_up; i++) begin
      wall_ms += $urandom_range(0, step_max);
      send_sample($urandom_range(7) != 0, wall_ms, $urandom_range(2) == 0);
    end
  endtask

  task automatic test_random_presses(input int send_pct, input int recv_pct, input int count);
    int target;
    int block_end;
    int mode;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    target = samples_sent + count;
    while (samples_sent < target) begin
      // Retime only while nothing is in flight
      drain_samples();
      mode = $urandom_range(7);
      case (mode)
        0: begin
          write_timing(CFG_DEBOUNCE, 16'd0);
          write_timing(CFG_HOLD, 16'd0);
        end
        1: begin
          write_timing(CFG_DEBOUNCE, 16'hFFFF);
          write_timing(CFG_HOLD, 16'hFFFF);
        end
        2: begin
          write_timing(CFG_DEBOUNCE, 16'($urandom_range(0, 40)));
          write_timing(CFG_HOLD, 16'd0);
        end
        default: begin
          write_timing(CFG_DEBOUNCE, 16'($urandom_range(0, 40)));
          write_timing(CFG_HOLD, 16'($urandom_range(0, 150)));
        end
      endcase
      block_end = samples_sent + 60;
      while (samples_sent < block_end && samples_sent < target) begin
        if ($urandom_range(5) == 0) begin
          repeat ($urandom_range(1, 4)) begin
            send_sample(1'($urandom_range(1)), $urandom, 1'($urandom_range(1)));
          end
        end else begin
          send_press_episode();
        end
      end
    end
  endtask

  // Receiver: random backpressure and in-order compare
  always @(posedge clk_i) begin
    out_t exp;
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_ni && out_valid_o && out_ready) begin
      if (predicted_reports.size() == 0) begin
        note_failure($sformatf("report with no sample pending: state=%0d clicked=%0b",
                               out_data_o.button_state, out_data_o.clicked));
      end else begin
        exp = predicted_reports.pop_front();
        if (out_data_o.button_state !== exp.button_state ||
            out_data_o.clicked !== exp.clicked) begin
          note_failure($sformatf("state exp %0d got %0d, clicked exp %0b got %0b",
                                 exp.button_state, out_data_o.button_state,
                                 exp.clicked, out_data_o.clicked));
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    debounce_lim = DEBOUNCE_RST;
    hold_lim = HOLD_RST;
    btn_state = ST_RELEASED;
    debounce_open = 1'b0;
    window_start_ms = '0;
    click_flag = 1'b0;
    send_idle_pct = 13;
    recv_idle_pct = 66;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_press_release_click();
    test_timing_corners();
    test_random_presses(13, 66, 230);
    test_random_presses(66, 13, 230);
    test_random_presses(0, 0, 230);

    // Let trailing reports arrive, then judge
    drain_samples();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (predicted_reports.size() != 0) begin
      note_failure($sformatf("%0d reports never arrived", predicted_reports.size()));
    end
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
